>>> rtl/core/mpd_pkg.sv
`timescale 1ns / 1ps
package mpd_pkg;

    localparam int MAX_BOUNDARY_BYTES = 32;
    localparam int BND_BITS = MAX_BOUNDARY_BYTES * 8;

    localparam logic [7:0] CH_DASH = 8'h2D;
    localparam logic [7:0] CH_CR   = 8'h0D;
    localparam logic [7:0] CH_LF   = 8'h0A;
    localparam logic [32:0] TAIL_BYTES = 33'd4;

    // register index, taken from paddr[5:3]
    localparam logic [2:0] REG_BND_LEN   = 3'd0;
    localparam logic [2:0] REG_BND_WORD0 = 3'd1;
    localparam logic [2:0] REG_BND_WORD1 = 3'd2;
    localparam logic [2:0] REG_BND_WORD2 = 3'd3;
    localparam logic [2:0] REG_BND_WORD3 = 3'd4;
    localparam logic [2:0] REG_BODY_LEN  = 3'd5;

    typedef enum logic [2:0] {
        KIND_HDR_BYTE    = 3'd0,
        KIND_LINE_END    = 3'd1,
        KIND_DATA_START  = 3'd2,
        KIND_DATA_BYTE   = 3'd3,
        KIND_PART_END    = 3'd4,
        KIND_DONE        = 3'd5,
        KIND_DONE_FIXED  = 3'd6,
        KIND_ERROR       = 3'd7
    } kind_t;

    typedef enum logic [3:0] {
        PH_OPEN     = 4'd0,
        PH_HEADERS  = 4'd1,
        PH_DATA     = 4'd2,
        PH_FEED1    = 4'd3,
        PH_DASH1    = 4'd4,
        PH_DASH2    = 4'd5,
        PH_MATCH    = 4'd6,
        PH_AFTER    = 4'd7,
        PH_FEED2    = 4'd8,
        PH_FINISHED = 4'd9,
        PH_ERROR    = 4'd10
    } phase_t;

    typedef enum logic [1:0] {
        CS_IDLE   = 2'd0,
        CS_PREFIX = 2'd1,
        CS_CR     = 2'd2,
        CS_TAIL   = 2'd3
    } ctrl_state_t;

    typedef enum logic [1:0] {
        SRC_PREFIX = 2'd0,
        SRC_CR     = 2'd1,
        SRC_TAIL   = 2'd2
    } src_t;

    typedef struct packed {
        logic accept;
        logic emit;
        src_t src;
        logic last;
    } mpd_cmd_t;

    typedef struct packed {
        logic plan_prefix;
        logic plan_cr;
        logic plan_tail;
        logic has_cr;
        logic has_tail;
        logic prefix_nz;
        logic prefix_last;
        logic out_valid;
    } mpd_sts_t;

    function automatic logic [7:0] bnd_byte(input logic [BND_BITS-1:0] bytes,
                                            input logic [4:0] k);
        bnd_byte = bytes[{k, 3'b000} +: 8];
    endfunction

endpackage

>>> rtl/core/mpd_regs.sv
`timescale 1ns / 1ps
module mpd_regs (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready,
    output logic [5:0]  bnd_len,
    output logic [mpd_pkg::BND_BITS-1:0] bnd_bytes,
    output logic [31:0] body_length
);

    logic [5:0]  len_reg;
    logic [63:0] word0_reg, word1_reg, word2_reg, word3_reg;
    logic [31:0] body_len_reg;
    logic        wr_en;
    logic [2:0]  idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = paddr[5:3];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg      <= 6'd1;
            word0_reg    <= '0;
            word1_reg    <= '0;
            word2_reg    <= '0;
            word3_reg    <= '0;
            body_len_reg <= '0;
        end else if (wr_en) begin
            case (idx)
                mpd_pkg::REG_BND_LEN:   len_reg      <= pwdata[5:0];
                mpd_pkg::REG_BND_WORD0: word0_reg    <= pwdata;
                mpd_pkg::REG_BND_WORD1: word1_reg    <= pwdata;
                mpd_pkg::REG_BND_WORD2: word2_reg    <= pwdata;
                mpd_pkg::REG_BND_WORD3: word3_reg    <= pwdata;
                mpd_pkg::REG_BODY_LEN:  body_len_reg <= pwdata[31:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            mpd_pkg::REG_BND_LEN:   prdata = {58'd0, len_reg};
            mpd_pkg::REG_BND_WORD0: prdata = word0_reg;
            mpd_pkg::REG_BND_WORD1: prdata = word1_reg;
            mpd_pkg::REG_BND_WORD2: prdata = word2_reg;
            mpd_pkg::REG_BND_WORD3: prdata = word3_reg;
            mpd_pkg::REG_BODY_LEN:  prdata = {32'd0, body_len_reg};
            default:                prdata = '0;
        endcase
    end

    assign bnd_len     = len_reg;
    assign bnd_bytes   = {word3_reg, word2_reg, word1_reg, word0_reg};
    assign body_length = body_len_reg;

endmodule

>>> rtl/core/mpd_datapath.sv
`timescale 1ns / 1ps
module mpd_datapath (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic [7:0]          in_byte,
    input  logic                in_start,
    input  logic [5:0]          bnd_len,
    input  logic [mpd_pkg::BND_BITS-1:0] bnd_bytes,
    input  logic [31:0]         body_length,
    input  mpd_pkg::mpd_cmd_t   cmd,
    input  logic                m_tready,
    output mpd_pkg::mpd_sts_t   sts,
    output logic                out_valid,
    output logic [2:0]          out_kind,
    output logic [7:0]          out_byte,
    output logic                out_last
);

    // parse state
    mpd_pkg::phase_t phase_reg, phase_next;
    logic [31:0]     pos_reg, pos_next;
    logic [5:0]      mpos_reg, mpos_next;
    logic            busy_reg, busy_next;

    // result plan for the current item
    logic [5:0]      plen_reg, plen_next;
    logic            cr_reg, cr_next;
    logic            tail_reg, tail_next;
    mpd_pkg::kind_t  tkind_reg, tkind_next;
    logic [7:0]      tbyte_reg, tbyte_next;
    logic [5:0]      idx_reg, idx_next;

    // output register
    logic            out_valid_reg, out_valid_next;
    logic [2:0]      out_kind_reg;
    logic [7:0]      out_byte_reg;
    logic            out_last_reg;

    logic [5:0]      len;
    logic [31:0]     pos;
    logic [31:0]     off;
    mpd_pkg::phase_t phase;
    logic [5:0]      mpos;
    logic            busy;
    logic [7:0]      pre_byte;
    logic [2:0]      sel_kind;
    logic [7:0]      sel_byte;

    always_comb begin
        if (bnd_len == 6'd0) begin
            len = 6'd1;
        end else if (bnd_len > 6'(mpd_pkg::MAX_BOUNDARY_BYTES)) begin
            len = 6'(mpd_pkg::MAX_BOUNDARY_BYTES);
        end else begin
            len = bnd_len;
        end
    end

    always_comb begin
        pos        = in_start ? 32'd0 : pos_reg;
        phase      = (pos == 32'd0) ? mpd_pkg::PH_OPEN : phase_reg;
        mpos       = (pos == 32'd0) ? 6'd0 : mpos_reg;
        busy       = (pos == 32'd0) ? 1'b0 : busy_reg;
        off        = pos - 32'd2;
        phase_next = phase;
        mpos_next  = mpos;
        busy_next  = busy;
        plen_next  = 6'd0;
        cr_next    = 1'b0;
        tail_next  = 1'b0;
        tkind_next = mpd_pkg::KIND_DATA_BYTE;
        tbyte_next = 8'd0;
        pos_next   = (pos == 32'hFFFF_FFFF) ? pos : pos + 32'd1;

        case (phase)
            mpd_pkg::PH_OPEN: begin
                if (pos < 32'd2) begin
                    if (in_byte != mpd_pkg::CH_DASH) begin
                        phase_next = mpd_pkg::PH_ERROR;
                        tail_next  = 1'b1;
                        tkind_next = mpd_pkg::KIND_ERROR;
                    end
                end else if (off < {26'd0, len}) begin
                    if (in_byte != mpd_pkg::bnd_byte(bnd_bytes, off[4:0])) begin
                        phase_next = mpd_pkg::PH_ERROR;
                        tail_next  = 1'b1;
                        tkind_next = mpd_pkg::KIND_ERROR;
                    end
                end else if (off == {26'd0, len}) begin
                    if (in_byte != mpd_pkg::CH_CR) begin
                        phase_next = mpd_pkg::PH_ERROR;
                        tail_next  = 1'b1;
                        tkind_next = mpd_pkg::KIND_ERROR;
                    end
                end else if (off == {26'd0, len} + 32'd1) begin
                    if (in_byte != mpd_pkg::CH_LF) begin
                        phase_next = mpd_pkg::PH_ERROR;
                        tail_next  = 1'b1;
                        tkind_next = mpd_pkg::KIND_ERROR;
                    end else begin
                        phase_next = mpd_pkg::PH_HEADERS;
                        busy_next  = 1'b0;
                    end
                end
            end
            mpd_pkg::PH_HEADERS: begin
                if (in_byte == mpd_pkg::CH_LF) begin
                    tail_next = 1'b1;
                    if (busy) begin
                        tkind_next = mpd_pkg::KIND_LINE_END;
                        busy_next  = 1'b0;
                    end else begin
                        tkind_next = mpd_pkg::KIND_DATA_START;
                        phase_next = mpd_pkg::PH_DATA;
                    end
                end else if (in_byte != mpd_pkg::CH_CR) begin
                    tail_next  = 1'b1;
                    tkind_next = mpd_pkg::KIND_HDR_BYTE;
                    tbyte_next = in_byte;
                    busy_next  = 1'b1;
                end
            end
            mpd_pkg::PH_DATA,
            mpd_pkg::PH_FEED1,
            mpd_pkg::PH_DASH1,
            mpd_pkg::PH_DASH2,
            mpd_pkg::PH_MATCH,
            mpd_pkg::PH_AFTER,
            mpd_pkg::PH_FEED2: begin
                // ordinary data byte unless a delimiter step takes it below
                phase_next = (in_byte == mpd_pkg::CH_CR) ? mpd_pkg::PH_FEED1
                                                          : mpd_pkg::PH_DATA;
                tail_next  = (in_byte != mpd_pkg::CH_CR);
                tkind_next = mpd_pkg::KIND_DATA_BYTE;
                tbyte_next = in_byte;
                case (phase)
                    mpd_pkg::PH_FEED1: begin
                        if (in_byte == mpd_pkg::CH_LF) begin
                            phase_next = mpd_pkg::PH_DASH1;
                            tail_next  = 1'b0;
                        end else begin
                            plen_next = 6'd1;
                        end
                    end
                    mpd_pkg::PH_DASH1: begin
                        if (in_byte == mpd_pkg::CH_DASH) begin
                            phase_next = mpd_pkg::PH_DASH2;
                            tail_next  = 1'b0;
                        end else begin
                            plen_next = 6'd2;
                        end
                    end
                    mpd_pkg::PH_DASH2: begin
                        if (in_byte == mpd_pkg::CH_DASH) begin
                            phase_next = mpd_pkg::PH_MATCH;
                            mpos_next  = 6'd0;
                            tail_next  = 1'b0;
                        end else begin
                            plen_next = 6'd3;
                        end
                    end
                    mpd_pkg::PH_MATCH: begin
                        if (mpos < len &&
                            mpd_pkg::bnd_byte(bnd_bytes, mpos[4:0]) != in_byte) begin
                            plen_next = mpos + 6'd4;
                        end else if (mpos + 6'd1 >= len) begin
                            phase_next = mpd_pkg::PH_AFTER;
                            tkind_next = mpd_pkg::KIND_PART_END;
                            tbyte_next = 8'd0;
                            tail_next  = 1'b1;
                        end else begin
                            phase_next = mpd_pkg::PH_MATCH;
                            mpos_next  = mpos + 6'd1;
                            tail_next  = 1'b0;
                        end
                    end
                    mpd_pkg::PH_AFTER: begin
                        if (in_byte == mpd_pkg::CH_CR) begin
                            phase_next = mpd_pkg::PH_FEED2;
                        end else if (in_byte == mpd_pkg::CH_DASH) begin
                            phase_next = mpd_pkg::PH_FINISHED;
                            tbyte_next = 8'd0;
                            tail_next  = 1'b1;
                            tkind_next = ({1'b0, body_length} !=
                                          {1'b0, pos} + mpd_pkg::TAIL_BYTES)
                                         ? mpd_pkg::KIND_DONE_FIXED
                                         : mpd_pkg::KIND_DONE;
                        end else begin
                            plen_next = len + 6'd4;
                        end
                    end
                    mpd_pkg::PH_FEED2: begin
                        if (in_byte == mpd_pkg::CH_LF) begin
                            phase_next = mpd_pkg::PH_HEADERS;
                            busy_next  = 1'b0;
                            tail_next  = 1'b0;
                        end else begin
                            plen_next = len + 6'd4;
                            cr_next   = 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= mpd_pkg::PH_OPEN;
            pos_reg   <= '0;
            mpos_reg  <= '0;
            busy_reg  <= 1'b0;
            plen_reg  <= '0;
            cr_reg    <= 1'b0;
            tail_reg  <= 1'b0;
            idx_reg   <= '0;
        end else begin
            if (cmd.accept) begin
                phase_reg <= phase_next;
                pos_reg   <= pos_next;
                mpos_reg  <= mpos_next;
                busy_reg  <= busy_next;
                plen_reg  <= plen_next;
                cr_reg    <= cr_next;
                tail_reg  <= tail_next;
            end
            idx_reg <= idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            tkind_reg <= tkind_next;
            tbyte_reg <= tbyte_next;
        end
    end

    always_comb begin
        if (cmd.accept) begin
            idx_next = 6'd0;
        end else if (cmd.emit && cmd.src == mpd_pkg::SRC_PREFIX) begin
            idx_next = idx_reg + 6'd1;
        end else begin
            idx_next = idx_reg;
        end
    end

    // replay text: CR LF dash dash, then the boundary bytes
    always_comb begin
        if (idx_reg < 6'd4) begin
            case (idx_reg[1:0])
                2'd0:    pre_byte = mpd_pkg::CH_CR;
                2'd1:    pre_byte = mpd_pkg::CH_LF;
                default: pre_byte = mpd_pkg::CH_DASH;
            endcase
        end else begin
            pre_byte = mpd_pkg::bnd_byte(bnd_bytes, 5'(idx_reg - 6'd4));
        end
    end

    always_comb begin
        case (cmd.src)
            mpd_pkg::SRC_PREFIX: begin
                sel_kind = mpd_pkg::KIND_DATA_BYTE;
                sel_byte = pre_byte;
            end
            mpd_pkg::SRC_CR: begin
                sel_kind = mpd_pkg::KIND_DATA_BYTE;
                sel_byte = mpd_pkg::CH_CR;
            end
            default: begin
                sel_kind = tkind_reg;
                sel_byte = tbyte_reg;
            end
        endcase
    end

    always_comb begin
        if (cmd.emit) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            out_kind_reg <= sel_kind;
            out_byte_reg <= sel_byte;
            out_last_reg <= cmd.last;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_kind  = out_kind_reg;
    assign out_byte  = out_byte_reg;
    assign out_last  = out_last_reg;

    assign sts.plan_prefix = (plen_next != 6'd0);
    assign sts.plan_cr     = cr_next;
    assign sts.plan_tail   = tail_next;
    assign sts.has_cr      = cr_reg;
    assign sts.has_tail    = tail_reg;
    assign sts.prefix_nz   = (plen_reg != 6'd0);
    assign sts.prefix_last = (idx_reg + 6'd1 == plen_reg);
    assign sts.out_valid   = out_valid_reg;

endmodule

>>> rtl/core/mpd_ctrl.sv
`timescale 1ns / 1ps
module mpd_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic                m_tready,
    input  mpd_pkg::mpd_sts_t   sts,
    output mpd_pkg::mpd_cmd_t   cmd
);

    mpd_pkg::ctrl_state_t state_reg, state_next;
    logic can_emit;

    assign can_emit = !sts.out_valid || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= mpd_pkg::CS_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            mpd_pkg::CS_IDLE: begin
                if (s_tvalid) begin
                    if (sts.plan_prefix) begin
                        state_next = mpd_pkg::CS_PREFIX;
                    end else if (sts.plan_cr) begin
                        state_next = mpd_pkg::CS_CR;
                    end else if (sts.plan_tail) begin
                        state_next = mpd_pkg::CS_TAIL;
                    end
                end
            end
            mpd_pkg::CS_PREFIX: begin
                if (can_emit && sts.prefix_last) begin
                    if (sts.has_cr) begin
                        state_next = mpd_pkg::CS_CR;
                    end else if (sts.has_tail) begin
                        state_next = mpd_pkg::CS_TAIL;
                    end else begin
                        state_next = mpd_pkg::CS_IDLE;
                    end
                end
            end
            mpd_pkg::CS_CR: begin
                if (can_emit) begin
                    state_next = sts.has_tail ? mpd_pkg::CS_TAIL : mpd_pkg::CS_IDLE;
                end
            end
            mpd_pkg::CS_TAIL: begin
                if (can_emit) begin
                    state_next = mpd_pkg::CS_IDLE;
                end
            end
            default: state_next = mpd_pkg::CS_IDLE;
        endcase
    end

    always_comb begin
        s_tready   = 1'b0;
        cmd.accept = 1'b0;
        cmd.emit   = 1'b0;
        cmd.src    = mpd_pkg::SRC_TAIL;
        cmd.last   = 1'b0;
        case (state_reg)
            mpd_pkg::CS_IDLE: begin
                s_tready   = 1'b1;
                cmd.accept = s_tvalid;
            end
            mpd_pkg::CS_PREFIX: begin
                cmd.emit = can_emit;
                cmd.src  = mpd_pkg::SRC_PREFIX;
                cmd.last = sts.prefix_last && !sts.has_cr && !sts.has_tail;
            end
            mpd_pkg::CS_CR: begin
                cmd.emit = can_emit;
                cmd.src  = mpd_pkg::SRC_CR;
                cmd.last = !sts.has_tail;
            end
            mpd_pkg::CS_TAIL: begin
                cmd.emit = can_emit;
                cmd.src  = mpd_pkg::SRC_TAIL;
                cmd.last = 1'b1;
            end
            default: ;
        endcase
    end

    a_prefix_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == mpd_pkg::CS_PREFIX |-> sts.prefix_nz)
        else $error("replay state entered with empty replay");

    a_silent_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.accept && !sts.plan_prefix && !sts.plan_cr && !sts.plan_tail)
        |=> state_reg == mpd_pkg::CS_IDLE)
        else $error("item without results left the idle state");

    a_last_ends_run: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.emit && cmd.last) |=> state_reg == mpd_pkg::CS_IDLE)
        else $error("final result did not return to idle");

    a_no_emit_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (sts.out_valid && !m_tready) |-> !cmd.emit)
        else $error("result overwritten while stalled");

endmodule

>>> rtl/core/multipart_body_deframer.sv
// Order: an accepted byte's plan is registered first, then fed to the output register.
// Throughput: bytes are taken only while the sequencer is idle; one result per cycle
// is emitted unless the output stalls; a failed delimiter gives up to 38 results.
// Reset: synchronous, active-low aresetn clears parser, sequencer and output valid,
// and returns boundary_len to 1 and all other configuration registers to 0.
`timescale 1ns / 1ps
module multipart_body_deframer (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] body_byte
    input  logic        s_tuser,    // [0] start_of_body
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,    // [7:0] out_byte
    output logic [2:0]  m_tuser,    // [2:0] kind
    output logic        m_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);

    logic [5:0]                       bnd_len;
    logic [mpd_pkg::BND_BITS-1:0]     bnd_bytes;
    logic [31:0]                      body_length;
    mpd_pkg::mpd_cmd_t                cmd;
    mpd_pkg::mpd_sts_t                sts;

    mpd_regs u_regs (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .bnd_len     (bnd_len),
        .bnd_bytes   (bnd_bytes),
        .body_length (body_length)
    );

    mpd_datapath u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_byte     (s_tdata),
        .in_start    (s_tuser),
        .bnd_len     (bnd_len),
        .bnd_bytes   (bnd_bytes),
        .body_length (body_length),
        .cmd         (cmd),
        .m_tready    (m_tready),
        .sts         (sts),
        .out_valid   (m_tvalid),
        .out_kind    (m_tuser),
        .out_byte    (m_tdata),
        .out_last    (m_tlast)
    );

    mpd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

endmodule
